[src/ultrasonic_echo_ranger_unit_assert.svh]
// Assertion macros for the ultrasonic echo ranger unit.
// Depends on nothing; the including module supplies clock and reset names.
`ifndef ULTRASONIC_ECHO_RANGER_UNIT_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define UER_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("uer assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define UER_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("uer assertion failed: next-cycle implication");

`endif

[src/uer_pkg.sv]
// Package for the ultrasonic echo ranger: types, register codes and constants.
// Used by uer_step and ultrasonic_echo_ranger_unit; depends on nothing.
package uer_pkg;

   localparam int COUNT_WIDTH_DEF = 24;
   localparam int DIST_WIDTH      = 19;
   localparam int DIST_SHIFT      = 24;

   localparam logic [DIST_WIDTH-1:0] DIST_MULT = 19'd287728;
   localparam logic [DIST_WIDTH-1:0] DIST_MAX  = 19'd287727;

   localparam logic [15:0] BURST_RESET   = 16'd2400;
   localparam logic [15:0] BLANK_RESET   = 16'd24000;
   localparam logic [11:0] CARRIER_RESET = 12'd408;
   localparam logic [23:0] TIMEOUT_RESET = 24'd1048575;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_BURST  = 2'd1,
      PH_BLANK  = 2'd2,
      PH_LISTEN = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      CSR_BURST   = 2'd0,
      CSR_BLANK   = 2'd1,
      CSR_CARRIER = 2'd2,
      CSR_TIMEOUT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [15:0] burst_ticks;
      logic [15:0] blank_ticks;
      logic [11:0] carrier_half_ticks;
      logic [23:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      logic [15:0] phase_count;
      logic [11:0] carrier_count;
      logic        carrier_level;
      logic        echo_prev;
   } core_state_type;

   typedef struct packed {
      logic                  tx_drive;
      logic                  busy_res;
      logic                  done_res;
      logic                  timed_out;
      logic [DIST_WIDTH-1:0] distance_x16;
   } result_type;

endpackage

[src/uer_step.sv]
// Next-state and result logic for one timer tick of the echo ranger.
// Depends on uer_pkg; purely combinational, registered by the top level.
module uer_step
   import uer_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  cfg_type                cfg,
   input  core_state_type         cur,
   input  logic [COUNT_WIDTH-1:0] tick_cur,
   input  logic                   start_req,
   input  logic                   echo,
   output core_state_type         nxt,
   output logic [COUNT_WIDTH-1:0] tick_nxt,
   output result_type             res
);

   localparam int CMP_W  = (COUNT_WIDTH > 24) ? COUNT_WIDTH : 24;
   localparam int PROD_W = COUNT_WIDTH + DIST_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

   logic [PROD_W-1:0] prod;
   logic [PROD_W-1:0] prod_sh;
   logic              done;
   logic              tout;

   // Distance from the updated count: count * 287728 >> 24, saturated.
   assign prod    = PROD_W'(tick_nxt) * PROD_W'(DIST_MULT);
   assign prod_sh = prod >> DIST_SHIFT;

   always_comb begin
      logic [11:0] cc_inc;
      logic [15:0] pc_inc;
      nxt       = cur;
      tick_nxt  = tick_cur;
      done      = 1'b0;
      tout      = 1'b0;
      cc_inc    = cur.carrier_count + 12'd1;
      pc_inc    = cur.phase_count + 16'd1;
      nxt.echo_prev = echo;

      if (cur.phase == PH_IDLE) begin
         if (start_req) begin
            nxt.phase         = PH_BURST;
            tick_nxt          = '0;
            nxt.phase_count   = '0;
            nxt.carrier_count = '0;
            nxt.carrier_level = 1'b1;
         end
      end else begin
         if (tick_cur != CNT_MAX) begin
            tick_nxt = tick_cur + COUNT_WIDTH'(1);
         end

         case (cur.phase)
            PH_BURST: begin
               if (cc_inc >= cfg.carrier_half_ticks) begin
                  nxt.carrier_count = '0;
                  nxt.carrier_level = ~cur.carrier_level;
               end else begin
                  nxt.carrier_count = cc_inc;
               end
               if (pc_inc >= cfg.burst_ticks) begin
                  nxt.phase_count   = '0;
                  nxt.carrier_count = '0;
                  nxt.carrier_level = 1'b0;
                  nxt.phase = (cfg.blank_ticks == 16'd0) ? PH_LISTEN : PH_BLANK;
               end else begin
                  nxt.phase_count = pc_inc;
               end
            end
            PH_BLANK: begin
               if (pc_inc >= cfg.blank_ticks) begin
                  nxt.phase_count = '0;
                  nxt.phase       = PH_LISTEN;
               end else begin
                  nxt.phase_count = pc_inc;
               end
            end
            PH_LISTEN: begin
               done = echo & ~cur.echo_prev;
            end
            default: begin
               done = 1'b0;
            end
         endcase

         // The echo edge takes precedence over the timeout on the same tick.
         if (!done && ((CMP_W'(tick_nxt) >= CMP_W'(cfg.timeout_ticks)) ||
                       (tick_nxt == CNT_MAX))) begin
            done = 1'b1;
            tout = 1'b1;
         end

         if (done) begin
            nxt.phase         = PH_IDLE;
            nxt.phase_count   = '0;
            nxt.carrier_count = '0;
            nxt.carrier_level = 1'b0;
         end
      end
   end

   always_comb begin
      res.tx_drive  = nxt.carrier_level;
      res.busy_res  = (nxt.phase != PH_IDLE);
      res.done_res  = done;
      res.timed_out = tout;
      if (!done) begin
         res.distance_x16 = '0;
      end else if (prod_sh > PROD_W'(DIST_MAX)) begin
         res.distance_x16 = DIST_MAX;
      end else begin
         res.distance_x16 = prod_sh[DIST_WIDTH-1:0];
      end
   end

endmodule

[src/ultrasonic_echo_ranger_unit.sv]
// Ultrasonic time-of-flight ranger top level: state registers, result register and APB port.
// Depends on uer_pkg, uer_step and ultrasonic_echo_ranger_unit_assert.svh.
// The result of a tick is registered and presented in the cycle after its transfer is accepted.
// Throughput: one tick per cycle via the single uer_step, unless a held result stalls it.
// Reset (synchronous, active high) returns control registers to defaults, the block to idle.
`include "ultrasonic_echo_ranger_unit_assert.svh"

module ultrasonic_echo_ranger_unit
   import uer_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Tick input channel.
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_start_req,
   input  logic        req_echo,
   // Result channel.
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_tx_drive,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic        rsp_timed_out,
   output logic [18:0] rsp_distance_x16,
   // Configuration port, APB style.
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // Configuration registers. The four registers sit at byte offsets 0, 4, 8
   // and 12, so the word index is simply paddr[3:2].
   cfg_type cfg_ff, cfg_in;

   // Measurement state. The phase counter, carrier counter and echo history
   // travel together as one struct; the tick counter is parameterised and is
   // kept apart.
   core_state_type         state_ff, state_in;
   logic [COUNT_WIDTH-1:0] tick_ff, tick_in;

   // Result register. A new tick is accepted whenever the register is empty
   // or its contents are being taken in the same cycle, so a stalled result
   // never holds up the tick stream longer than the consumer does.
   result_type result_ff, result_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic          req_fire;
   logic          cfg_write;
   csr_index_type csr_idx;

   assign pready    = 1'b1;
   assign csr_idx   = csr_index_type'(paddr[3:2]);
   assign cfg_write = psel & penable & pwrite;

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign req_fire  = req_valid & req_ready;

   // Register writes take effect at once, even mid-measurement.
   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         case (csr_idx)
            CSR_BURST:   cfg_in.burst_ticks        = pwdata[15:0];
            CSR_BLANK:   cfg_in.blank_ticks        = pwdata[15:0];
            CSR_CARRIER: cfg_in.carrier_half_ticks = pwdata[11:0];
            CSR_TIMEOUT: cfg_in.timeout_ticks      = pwdata[23:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_BURST:   prdata = {16'd0, cfg_ff.burst_ticks};
         CSR_BLANK:   prdata = {16'd0, cfg_ff.blank_ticks};
         CSR_CARRIER: prdata = {20'd0, cfg_ff.carrier_half_ticks};
         CSR_TIMEOUT: prdata = {8'd0, cfg_ff.timeout_ticks};
         default:     prdata = '0;
      endcase
   end

   // All of the per-tick work: phase sequencing, carrier toggling, edge
   // detection, timeout and the distance scaling.
   core_state_type         step_state;
   logic [COUNT_WIDTH-1:0] step_tick;
   result_type             step_res;

   uer_step #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_step (
      .cfg       (cfg_ff),
      .cur       (state_ff),
      .tick_cur  (tick_ff),
      .start_req (req_start_req),
      .echo      (req_echo),
      .nxt       (step_state),
      .tick_nxt  (step_tick),
      .res       (step_res)
   );

   // State only advances on an accepted transfer; idle cycles leave it alone.
   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (req_fire) begin
         state_in     = step_state;
         tick_in      = step_tick;
         result_in    = step_res;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.burst_ticks        <= BURST_RESET;
         cfg_ff.blank_ticks        <= BLANK_RESET;
         cfg_ff.carrier_half_ticks <= CARRIER_RESET;
         cfg_ff.timeout_ticks      <= TIMEOUT_RESET;
         state_ff.phase            <= PH_IDLE;
         state_ff.phase_count      <= '0;
         state_ff.carrier_count    <= '0;
         state_ff.carrier_level    <= 1'b0;
         state_ff.echo_prev        <= 1'b0;
         tick_ff                   <= '0;
         rsp_valid_ff              <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The result payload needs no reset: it is qualified by rsp_valid.
   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tx_drive     = result_ff.tx_drive;
   assign rsp_busy_res     = result_ff.busy_res;
   assign rsp_done_res     = result_ff.done_res;
   assign rsp_timed_out    = result_ff.timed_out;
   assign rsp_distance_x16 = result_ff.distance_x16;

   // A finished measurement always reports the block as no longer busy.
   `UER_ASSERT_IMP(a_done_not_busy, clock, reset, rsp_valid && rsp_done_res, !rsp_busy_res)
   // A timeout is only ever flagged together with done.
   `UER_ASSERT_IMP(a_tout_with_done, clock, reset, rsp_valid && rsp_timed_out, rsp_done_res)
   // The carrier is only ever high during the burst phase.
   `UER_ASSERT_IMP(a_carrier_burst, clock, reset, state_ff.carrier_level,
      state_ff.phase == PH_BURST)
   // An accepted tick always leaves a result waiting in the next cycle.
   `UER_ASSERT_NXT(a_fire_gives_result, clock, reset, req_fire, rsp_valid)

endmodule
